// ===== hdl/ncs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types, constants and distance helpers for the palette search block.
// ----------------------------------------------------------------------------
package ncs_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
   localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
   localparam int COUNT_W       = 9;
   localparam int INDEX_W       = 8;
   localparam int CHAN_W        = 8;
   localparam int WORD_W        = 4 * CHAN_W;
   localparam int DIST_W        = CHAN_W + 2;
   localparam int BEST_W        = DIST_W + 1;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BEST_W-1:0] START_BEST = BEST_W'(1024);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAP  = 1'b1;

   typedef struct packed {
      logic                is_map;
      logic                write_ok;
      logic [INDEX_W-1:0]  entry_index;
      logic [WORD_W-1:0]   pixel;
   } item_type;

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   waddr;
      logic [WORD_W-1:0]   wdata;
      logic                re;
      logic [ADDR_W-1:0]   raddr;
   } ram_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH,
      ST_RESULT
   } back_state_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [DIST_W-1:0] distance(input logic [WORD_W-1:0] word,
                                                 input logic [WORD_W-1:0] pix);
      logic [DIST_W-1:0] sum;
      sum = '0;
      for (int c = 0; c < 4; c++) begin
         sum = sum + DIST_W'(abs_diff(word[c*CHAN_W +: CHAN_W], pix[c*CHAN_W +: CHAN_W]));
      end
      return sum;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ncs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ncs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [$clog2(DEPTH)-1:0]  waddr,
   input  wire logic [WIDTH-1:0]          wdata,
   input  wire logic                      re,
   input  wire logic [$clog2(DEPTH)-1:0]  raddr,
   output logic      [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hdl/ncs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_front
// Request intake: classifies each command and queues it for the search engine.
// ----------------------------------------------------------------------------
module ncs_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic                          command,
   input  wire logic [ncs_pkg::INDEX_W-1:0]   entry_index,
   input  wire logic [ncs_pkg::WORD_W-1:0]    pixel,
   output logic                               item_valid,
   output ncs_pkg::item_type                  item,
   input  wire logic                          item_pop
);

   ncs_pkg::item_type                 mem_ff [ncs_pkg::QUEUE_DEPTH];
   ncs_pkg::item_type                 new_item;
   logic [ncs_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ncs_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ncs_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                              push_ok;
   logic                              pop_ok;

   assign full       = (cnt_ff == ncs_pkg::QCNT_W'(ncs_pkg::QUEUE_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign push_ok    = push && !full;
   assign pop_ok     = item_pop && item_valid;
   assign item       = mem_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_map      = (command == ncs_pkg::CMD_MAP);
      new_item.write_ok    = (command == ncs_pkg::CMD_LOAD) &&
                             (ncs_pkg::COUNT_W'(entry_index) <
                              ncs_pkg::COUNT_W'(ncs_pkg::PALETTE_DEPTH));
      new_item.entry_index = entry_index;
      new_item.pixel       = pixel;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == ncs_pkg::QPTR_W'(ncs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ncs_pkg::QPTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == ncs_pkg::QPTR_W'(ncs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ncs_pkg::QPTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + ncs_pkg::QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - ncs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ncs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_back
// Search engine: writes palette loads, scans entries for map commands and
// holds the result until it is popped.
// ----------------------------------------------------------------------------
module ncs_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  wire ncs_pkg::item_type             item,
   output logic                               item_pop,
   input  wire logic [ncs_pkg::COUNT_W-1:0]   palette_count,
   output ncs_pkg::ram_req_type               ram_req,
   input  wire logic [ncs_pkg::WORD_W-1:0]    ram_rdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_pop,
   output logic [ncs_pkg::INDEX_W-1:0]        rsp_index
);

   ncs_pkg::back_state_type           state_ff, state_in;
   logic [ncs_pkg::CNT_W-1:0]         addr_ff, addr_in;
   logic [ncs_pkg::CNT_W-1:0]         limit_ff, limit_in;
   logic [ncs_pkg::CNT_W-1:0]         clamp;
   logic [ncs_pkg::WORD_W-1:0]        pixel_ff, pixel_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [ncs_pkg::ADDR_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [ncs_pkg::BEST_W-1:0]        best_ff, best_in;
   logic [ncs_pkg::ADDR_W-1:0]        best_idx_ff, best_idx_in;
   logic                              out_valid_ff, out_valid_in;
   logic [ncs_pkg::INDEX_W-1:0]       out_idx_ff, out_idx_in;
   logic [ncs_pkg::DIST_W-1:0]        cand_dist;

   assign clamp = (palette_count > ncs_pkg::COUNT_W'(ncs_pkg::PALETTE_DEPTH)) ?
                  ncs_pkg::CNT_W'(ncs_pkg::PALETTE_DEPTH) :
                  ncs_pkg::CNT_W'(palette_count);
   assign cand_dist = ncs_pkg::distance(ram_rdata, pixel_ff);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      limit_in     = limit_ff;
      pixel_in     = pixel_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_idx_in   = out_idx_ff;
      item_pop     = 1'b0;
      ram_req      = '0;

      // strict less-than keeps the lowest index on ties
      if (rd_valid_ff && (ncs_pkg::BEST_W'(cand_dist) < best_ff)) begin
         best_in     = ncs_pkg::BEST_W'(cand_dist);
         best_idx_in = rd_idx_ff;
      end

      unique case (state_ff)
         ncs_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.is_map) begin
                  pixel_in    = item.pixel;
                  limit_in    = clamp;
                  addr_in     = '0;
                  best_in     = ncs_pkg::START_BEST;
                  best_idx_in = '0;
                  state_in    = (clamp == '0) ? ncs_pkg::ST_RESULT : ncs_pkg::ST_SEARCH;
               end else begin
                  ram_req.we    = item.write_ok;
                  ram_req.waddr = item.entry_index[ncs_pkg::ADDR_W-1:0];
                  ram_req.wdata = item.pixel;
               end
            end
         end
         ncs_pkg::ST_SEARCH: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = addr_ff[ncs_pkg::ADDR_W-1:0];
            rd_valid_in   = 1'b1;
            rd_idx_in     = addr_ff[ncs_pkg::ADDR_W-1:0];
            addr_in       = addr_ff + ncs_pkg::CNT_W'(1);
            if (addr_ff == limit_ff - ncs_pkg::CNT_W'(1)) begin
               state_in = ncs_pkg::ST_FINISH;
            end
         end
         ncs_pkg::ST_FINISH: begin
            state_in = ncs_pkg::ST_RESULT;
         end
         ncs_pkg::ST_RESULT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_idx_in   = ncs_pkg::INDEX_W'(best_idx_ff);
               state_in     = ncs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ncs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncs_pkg::ST_IDLE;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      limit_ff    <= limit_in;
      pixel_ff    <= pixel_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      out_idx_ff  <= out_idx_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_index = out_idx_ff;

`ifndef SYNTH
   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ncs_pkg::ST_SEARCH |-> addr_ff < limit_ff)
      else $error("search address beyond entry count");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ncs_pkg::CNT_W'(rd_idx_ff) < limit_ff)
      else $error("compared entry beyond entry count");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ncs_pkg::ST_RESULT))
      else $error("result appeared outside result state");

   a_map_starts: assert property (@(posedge clock) disable iff (reset)
      item_pop && item.is_map |=> state_ff != ncs_pkg::ST_IDLE)
      else $error("map command did not start a search");
`endif

endmodule
`default_nettype wire

// ===== hdl/nearest_palette_colour_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_colour_search
// Maps RGBA pixels to the closest palette entry by sum of channel differences.
// ----------------------------------------------------------------------------
// Requests enter through req_push/req_full: command 0 loads entry
// req_entry_index with the RGBA channels, command 1 maps the RGBA pixel.
// A two-entry request queue feeds the search engine.
// Results leave through rsp_empty/rsp_pop, one rsp_palette_index per map.
// csr_we writes csr_wdata into the entry count; the user must write it only
// while the block is idle, which the block itself does not enforce. A map
// scans N entries, N being the entry count clamped to the palette depth: one
// palette RAM read port delivers one entry per cycle to a single distance
// unit. With N = 0 a map returns index 0.
// Reset empties the queue and the result register and clears the count;
// palette contents are kept and are undefined until loaded.
// While the result waits to be popped, the queue keeps taking requests and
// loads still run; the next map holds its result until the slot frees.
// ----------------------------------------------------------------------------
module nearest_palette_colour_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_command,
   input  wire logic [ncs_pkg::INDEX_W-1:0]   req_entry_index,
   input  wire logic [ncs_pkg::CHAN_W-1:0]    req_red,
   input  wire logic [ncs_pkg::CHAN_W-1:0]    req_green,
   input  wire logic [ncs_pkg::CHAN_W-1:0]    req_blue,
   input  wire logic [ncs_pkg::CHAN_W-1:0]    req_alpha,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [ncs_pkg::INDEX_W-1:0]        rsp_palette_index,
   input  wire logic                          csr_we,
   input  wire logic [ncs_pkg::COUNT_W-1:0]   csr_wdata
);

   logic [ncs_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          item_valid;
   ncs_pkg::item_type             item;
   logic                          item_pop;
   ncs_pkg::ram_req_type          ram_req;
   logic [ncs_pkg::WORD_W-1:0]    ram_rdata;
   logic                          rsp_valid;

   assign count_in = csr_we ? csr_wdata : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   ncs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .command     (req_command),
      .entry_index (req_entry_index),
      .pixel       ({req_alpha, req_blue, req_green, req_red}),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   ncs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .palette_count (count_ff),
      .ram_req       (ram_req),
      .ram_rdata     (ram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_pop       (rsp_pop),
      .rsp_index     (rsp_palette_index)
   );

   ncs_ram #(
      .WIDTH (ncs_pkg::WORD_W),
      .DEPTH (ncs_pkg::PALETTE_DEPTH)
   ) u_palette_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   assign rsp_empty = !rsp_valid;

endmodule
`default_nettype wire
